// ===== sv/cartesian_spherical_converter_defines.svh =====
// ----------------------------------------------------------------------------
// Cartesian / spherical converter assertion macros
// Immediate-consequence and next-cycle property checks, removed for synthesis.
// ----------------------------------------------------------------------------
`ifndef CARTESIAN_SPHERICAL_CONVERTER_DEFINES_SVH
`define CARTESIAN_SPHERICAL_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS
// cons must hold in the same cycle as ante
`define CSC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// cons must hold in the cycle after ante
`define CSC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CSC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define CSC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== sv/csc_pkg.sv =====
// ----------------------------------------------------------------------------
// csc_pkg
// Shared constants, op codes and arctangent table for the coordinate converter.
// ----------------------------------------------------------------------------
package csc_pkg;

    localparam int CORDIC_STAGES_DEF = 32;
    localparam int COORD_WIDTH_DEF   = 32;
    localparam int ANGLE_WIDTH_DEF   = 32;

    // extra fraction bits carried inside the datapath
    localparam int GUARD = 8;

    // 1/K in Q0.31
    localparam logic [30:0] INV_GAIN = 31'h4DBA76D4;

    typedef enum logic [2:0] {
        OP_CART_RACODEC  = 3'd0,
        OP_CART_RADEC    = 3'd1,
        OP_RACODEC_CART  = 3'd2,
        OP_RADEC_CART    = 3'd3,
        OP_RACODEC_RADEC = 3'd4,
        OP_RADEC_RACODEC = 3'd5
    } t_op;

    // atan(2^-i) as 32-bit binary angles
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    // table entry rescaled to an aw-bit binary angle, rounded when narrowing
    function automatic logic [63:0] atan_step(input int idx, input int aw);
        logic [63:0] a;
        logic [63:0] half;
        a = 64'd0;
        if (idx < 32) begin
            a = {32'd0, ATAN_TAB[idx]};
        end
        if (aw >= 32) begin
            return a << (aw - 32);
        end
        half = 64'd1 << (31 - aw);
        return (a + half) >> (32 - aw);
    endfunction

endpackage

// ===== sv/csc_pass.sv =====
// ----------------------------------------------------------------------------
// csc_pass
// One pipelined CORDIC pass (vectoring or rotation per item), followed by a
// three-stage 1/K gain correction of the magnitude or of the y output.
// ----------------------------------------------------------------------------
module csc_pass
    import csc_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
    parameter int DATA_WIDTH    = COORD_WIDTH_DEF + GUARD + 4,
    parameter int SIDE_WIDTH    = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic                          i_vec,
    input  logic signed [DATA_WIDTH-1:0]  i_x,
    input  logic signed [DATA_WIDTH-1:0]  i_y,
    input  logic signed [ANGLE_WIDTH+2:0] i_ang,
    input  logic [SIDE_WIDTH-1:0]         i_side,
    output logic                          o_valid,
    output logic signed [DATA_WIDTH-1:0]  o_x,
    output logic signed [DATA_WIDTH-1:0]  o_y,
    output logic signed [ANGLE_WIDTH+2:0] o_ang,
    output logic signed [DATA_WIDTH-1:0]  o_mag,
    output logic [SIDE_WIDTH-1:0]         o_side
);

    localparam int DW = DATA_WIDTH;
    localparam int AW = ANGLE_WIDTH;
    localparam int ZW = ANGLE_WIDTH + 3;
    localparam int MW = DATA_WIDTH - 1;
    localparam int H  = (MW + 1) / 2;
    localparam int N  = CORDIC_STAGES;

    localparam logic signed [ZW-1:0] HALF_PI = {5'b00001, {(AW-2){1'b0}}};
    localparam logic signed [ZW-1:0] PI      = {4'b0001, {(AW-1){1'b0}}};
    localparam logic [MW+30:0]       ROUND   = (MW+31)'(1) << 30;

    // CORDIC datapath, index 0 is the quadrant-folded input
    logic                 r_valid [N+1];
    logic                 r_vec   [N+1];
    logic signed [DW-1:0] r_x     [N+1];
    logic signed [DW-1:0] r_y     [N+1];
    logic signed [ZW-1:0] r_z     [N+1];
    logic [SIDE_WIDTH-1:0] r_side [N+1];

    logic signed [DW-1:0] n_x0;
    logic signed [DW-1:0] n_y0;
    logic signed [ZW-1:0] n_z0;
    logic signed [ZW-1:0] w_zw;

    assign w_zw = {{3{i_ang[AW-1]}}, i_ang[AW-1:0]};

    always_comb begin
        n_x0 = i_x;
        n_y0 = i_y;
        n_z0 = '0;
        if (i_vec) begin
            if (i_x < 0) begin
                if (i_y >= 0) begin
                    n_x0 = i_y;
                    n_y0 = -i_x;
                    n_z0 = HALF_PI;
                end else begin
                    n_x0 = -i_y;
                    n_y0 = i_x;
                    n_z0 = -HALF_PI;
                end
            end
        end else begin
            n_y0 = '0;
            if (w_zw > HALF_PI) begin
                n_z0 = w_zw - PI;
                n_x0 = -i_x;
            end else if (w_zw < -HALF_PI) begin
                n_z0 = w_zw + PI;
                n_x0 = -i_x;
            end else begin
                n_z0 = w_zw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec[0]  <= i_vec;
            r_x[0]    <= n_x0;
            r_y[0]    <= n_y0;
            r_z[0]    <= n_z0;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_iter
        localparam logic [63:0]        STEP64 = atan_step(k, AW);
        localparam logic signed [ZW-1:0] STEP = STEP64[ZW-1:0];
        logic w_up;

        // up: x += y>>k, y -= x>>k, z += step
        assign w_up = r_vec[k] ? (r_y[k] >= 0) : (r_z[k] < 0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[k+1] <= r_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_vec[k+1]  <= r_vec[k];
                r_side[k+1] <= r_side[k];
                if (w_up) begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + STEP;
                end else begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - STEP;
                end
            end
        end
    end

    // gain correction: magnitude, split products, sum and sign
    logic                  r_g1_valid;
    logic                  r_g1_neg;
    logic [MW-1:0]         r_g1_m;
    logic signed [DW-1:0]  r_g1_x;
    logic signed [DW-1:0]  r_g1_y;
    logic signed [ZW-1:0]  r_g1_z;
    logic [SIDE_WIDTH-1:0] r_g1_side;

    logic                  r_g2_valid;
    logic                  r_g2_neg;
    logic [H+30:0]         r_g2_lo;
    logic [MW-H+30:0]      r_g2_hi;
    logic signed [DW-1:0]  r_g2_x;
    logic signed [DW-1:0]  r_g2_y;
    logic signed [ZW-1:0]  r_g2_z;
    logic [SIDE_WIDTH-1:0] r_g2_side;

    logic                  r_g3_valid;
    logic signed [DW-1:0]  r_g3_mag;
    logic signed [DW-1:0]  r_g3_x;
    logic signed [DW-1:0]  r_g3_y;
    logic signed [ZW-1:0]  r_g3_z;
    logic [SIDE_WIDTH-1:0] r_g3_side;

    logic signed [DW-1:0] n_g1_m;
    logic                 n_g1_neg;
    logic [MW+30:0]       w_g3_sum;
    logic signed [DW-1:0] w_g3_abs;

    always_comb begin
        n_g1_neg = 1'b0;
        if (r_vec[N]) begin
            n_g1_m = (r_x[N] < 0) ? '0 : r_x[N];
        end else begin
            n_g1_neg = r_y[N] < 0;
            n_g1_m   = n_g1_neg ? -r_y[N] : r_y[N];
        end
    end

    assign w_g3_sum = {r_g2_hi, {H{1'b0}}} + (MW+31)'(r_g2_lo) + ROUND;
    assign w_g3_abs = DW'(w_g3_sum[MW+30:31]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g1_valid <= 1'b0;
            r_g2_valid <= 1'b0;
            r_g3_valid <= 1'b0;
        end else if (i_en) begin
            r_g1_valid <= r_valid[N];
            r_g2_valid <= r_g1_valid;
            r_g3_valid <= r_g2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g1_neg  <= n_g1_neg;
            r_g1_m    <= n_g1_m[MW-1:0];
            r_g1_x    <= r_x[N];
            r_g1_y    <= r_y[N];
            r_g1_z    <= r_z[N];
            r_g1_side <= r_side[N];

            r_g2_neg  <= r_g1_neg;
            r_g2_lo   <= r_g1_m[H-1:0] * INV_GAIN;
            r_g2_hi   <= r_g1_m[MW-1:H] * INV_GAIN;
            r_g2_x    <= r_g1_x;
            r_g2_y    <= r_g1_y;
            r_g2_z    <= r_g1_z;
            r_g2_side <= r_g1_side;

            r_g3_mag  <= r_g2_neg ? -w_g3_abs : w_g3_abs;
            r_g3_x    <= r_g2_x;
            r_g3_y    <= r_g2_y;
            r_g3_z    <= r_g2_z;
            r_g3_side <= r_g2_side;
        end
    end

    assign o_valid = r_g3_valid;
    assign o_x     = r_g3_x;
    assign o_y     = r_g3_y;
    assign o_ang   = r_g3_z;
    assign o_mag   = r_g3_mag;
    assign o_side  = r_g3_side;

endmodule

// ===== sv/cartesian_spherical_converter.sv =====
// ----------------------------------------------------------------------------
// cartesian_spherical_converter
// Six conversions between Cartesian and spherical coordinates, two CORDIC passes.
// ----------------------------------------------------------------------------
// Fully pipelined: one conversion may be accepted every clock while o_stall is
// low. Each result passes in turn the input register, the gain pre-scale
// registers, the two CORDIC passes of CORDIC_STAGES+4 stages each and the
// output register. While a result is held on the output and stalled, the
// whole pipeline holds and o_stall is raised. Cartesian to spherical vectors
// (x,y) and then (z,rho); spherical to Cartesian rotates by the polar angle
// and then by right ascension. A zero input vector sets o_zero_vector; clamped
// Cartesian results set o_saturated.
`include "cartesian_spherical_converter_defines.svh"

module cartesian_spherical_converter
    import csc_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [2:0]                    i_op,
    input  logic signed [COORD_WIDTH-1:0] i_in_x,
    input  logic signed [COORD_WIDTH-1:0] i_in_y,
    input  logic signed [COORD_WIDTH-1:0] i_in_z,
    input  logic [COORD_WIDTH-1:0]        i_in_radius,
    input  logic signed [ANGLE_WIDTH-1:0] i_in_ra,
    input  logic signed [ANGLE_WIDTH:0]   i_in_polar,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [COORD_WIDTH-1:0] o_out_x,
    output logic signed [COORD_WIDTH-1:0] o_out_y,
    output logic signed [COORD_WIDTH-1:0] o_out_z,
    output logic [COORD_WIDTH-1:0]        o_out_radius,
    output logic signed [ANGLE_WIDTH-1:0] o_out_ra,
    output logic signed [ANGLE_WIDTH:0]   o_out_polar,
    output logic                          o_zero_vector,
    output logic                          o_saturated
);

    localparam int CW = COORD_WIDTH;
    localparam int AW = ANGLE_WIDTH;
    localparam int DW = COORD_WIDTH + GUARD + 4;
    localparam int ZW = ANGLE_WIDTH + 3;
    localparam int MW = DW - 1;
    localparam int H  = (MW + 1) / 2;

    localparam logic signed [ZW-1:0] HALF_PI_Z = {5'b00001, {(AW-2){1'b0}}};
    localparam logic signed [ZW-1:0] PI_Z      = {4'b0001, {(AW-1){1'b0}}};
    localparam logic signed [AW:0]   HALF_PI_P = {3'b001, {(AW-2){1'b0}}};
    localparam logic signed [AW:0]   PI_P      = {2'b01, {(AW-1){1'b0}}};
    localparam logic [MW+30:0]       ROUND     = (MW+31)'(1) << 30;
    localparam logic signed [DW-1:0] HALF_LSB  = DW'(1) << (GUARD - 1);
    localparam logic signed [DW-1:0] C_MAX     = {{(DW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [DW-1:0] C_MIN     = ~C_MAX;
    localparam logic signed [DW-1:0] R_MAX     = {{(DW-CW){1'b0}}, {CW{1'b1}}};

    typedef struct packed {
        t_op                  op;
        logic                 zv;
        logic                 axis;
        logic signed [CW-1:0] zin;
        logic [CW-1:0]        radius;
        logic signed [AW-1:0] ra;
        logic signed [AW:0]   polar;
        logic signed [DW-1:0] zc;
    } t_side;

    localparam int SIDE_W = $bits(t_side);

    logic w_en;

    assign w_en    = !o_valid || !i_stall;
    assign o_stall = !w_en;

    // ---------------- input stage ----------------
    t_op                  w_op;
    logic                 w_cart;
    logic                 w_xy0;
    logic signed [ZW-1:0] w_pol;
    t_side                n_s0_side;
    logic signed [ZW-1:0] n_s0_theta;

    assign w_op   = t_op'(i_op);
    assign w_cart = (w_op == OP_CART_RACODEC) || (w_op == OP_CART_RADEC);
    assign w_xy0  = (i_in_x == 0) && (i_in_y == 0);
    assign w_pol  = {{2{i_in_polar[AW]}}, i_in_polar};

    always_comb begin
        n_s0_side.op     = w_op;
        n_s0_side.zv     = w_cart && w_xy0 && (i_in_z == 0);
        n_s0_side.axis   = w_cart && w_xy0 && (i_in_z != 0);
        n_s0_side.zin    = i_in_z;
        n_s0_side.radius = i_in_radius;
        n_s0_side.ra     = i_in_ra;
        n_s0_side.polar  = HALF_PI_P - i_in_polar;
        n_s0_side.zc     = '0;
        n_s0_theta = (w_op == OP_RACODEC_CART) ? w_pol : HALF_PI_Z - w_pol;
    end

    logic                 r_s0_valid;
    logic                 r_s0_cart;
    t_side                r_s0_side;
    logic signed [ZW-1:0] r_s0_theta;
    logic signed [DW-1:0] r_s0_px;
    logic signed [DW-1:0] r_s0_py;

    // radius pre-scale by 1/K for the rotation ops
    logic                 r_a1_valid;
    logic                 r_a1_cart;
    t_side                r_a1_side;
    logic signed [ZW-1:0] r_a1_theta;
    logic signed [DW-1:0] r_a1_px;
    logic signed [DW-1:0] r_a1_py;
    logic [H+30:0]        r_a1_lo;
    logic [MW-H+30:0]     r_a1_hi;

    logic                 r_a2_valid;
    logic                 r_a2_cart;
    t_side                r_a2_side;
    logic signed [ZW-1:0] r_a2_theta;
    logic signed [DW-1:0] r_a2_px;
    logic signed [DW-1:0] r_a2_py;
    logic signed [DW-1:0] r_a2_v;

    logic [MW-1:0]  w_ma;
    logic [MW+30:0] w_sa;

    assign w_ma = MW'({r_s0_side.radius, {GUARD{1'b0}}});
    assign w_sa = {r_a1_hi, {H{1'b0}}} + (MW+31)'(r_a1_lo) + ROUND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_a1_valid <= 1'b0;
            r_a2_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= i_valid;
            r_a1_valid <= r_s0_valid;
            r_a2_valid <= r_a1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_cart  <= w_cart;
            r_s0_side  <= n_s0_side;
            r_s0_theta <= n_s0_theta;
            r_s0_px    <= {{(DW-CW-GUARD){i_in_x[CW-1]}}, i_in_x, {GUARD{1'b0}}};
            r_s0_py    <= {{(DW-CW-GUARD){i_in_y[CW-1]}}, i_in_y, {GUARD{1'b0}}};

            r_a1_cart  <= r_s0_cart;
            r_a1_side  <= r_s0_side;
            r_a1_theta <= r_s0_theta;
            r_a1_px    <= r_s0_px;
            r_a1_py    <= r_s0_py;
            r_a1_lo    <= w_ma[H-1:0] * INV_GAIN;
            r_a1_hi    <= w_ma[MW-1:H] * INV_GAIN;

            r_a2_cart  <= r_a1_cart;
            r_a2_side  <= r_a1_side;
            r_a2_theta <= r_a1_theta;
            r_a2_px    <= r_a1_px;
            r_a2_py    <= r_a1_py;
            r_a2_v     <= DW'(w_sa[MW+30:31]);
        end
    end

    // ---------------- first pass ----------------
    logic                 w_p1_valid;
    logic signed [DW-1:0] w_p1_x;
    logic signed [DW-1:0] w_p1_y;
    logic signed [ZW-1:0] w_p1_ang;
    logic signed [DW-1:0] w_p1_mag;
    logic [SIDE_W-1:0]    w_p1_side_raw;
    t_side                w_p1_side;

    csc_pass #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .ANGLE_WIDTH   (ANGLE_WIDTH),
        .DATA_WIDTH    (DW),
        .SIDE_WIDTH    (SIDE_W)
    ) u_pass1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_a2_valid),
        .i_vec   (r_a2_cart),
        .i_x     (r_a2_cart ? r_a2_px : r_a2_v),
        .i_y     (r_a2_cart ? r_a2_py : '0),
        .i_ang   (r_a2_theta),
        .i_side  (r_a2_side),
        .o_valid (w_p1_valid),
        .o_x     (w_p1_x),
        .o_y     (w_p1_y),
        .o_ang   (w_p1_ang),
        .o_mag   (w_p1_mag),
        .o_side  (w_p1_side_raw)
    );

    assign w_p1_side = t_side'(w_p1_side_raw);

    // ---------------- second pass ----------------
    logic                 w_p1_cart;
    t_side                n_p2_side;
    logic signed [DW-1:0] n_p2_x;
    logic signed [DW-1:0] n_p2_y;
    logic signed [ZW-1:0] n_p2_ang;

    assign w_p1_cart = (w_p1_side.op == OP_CART_RACODEC) || (w_p1_side.op == OP_CART_RADEC);

    always_comb begin
        n_p2_side = w_p1_side;
        n_p2_ang  = {{3{w_p1_side.ra[AW-1]}}, w_p1_side.ra};
        if (w_p1_cart) begin
            n_p2_side.ra = w_p1_ang[AW-1:0];
            n_p2_x = {{(DW-CW-GUARD){w_p1_side.zin[CW-1]}}, w_p1_side.zin, {GUARD{1'b0}}};
            n_p2_y = w_p1_mag;
        end else begin
            n_p2_side.zc = w_p1_x;
            n_p2_x = w_p1_mag;
            n_p2_y = '0;
        end
    end

    logic                 w_p2_valid;
    logic signed [DW-1:0] w_p2_x;
    logic signed [DW-1:0] w_p2_y;
    logic signed [ZW-1:0] w_p2_ang;
    logic signed [DW-1:0] w_p2_mag;
    logic [SIDE_W-1:0]    w_p2_side_raw;
    t_side                w_p2_side;

    csc_pass #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .ANGLE_WIDTH   (ANGLE_WIDTH),
        .DATA_WIDTH    (DW),
        .SIDE_WIDTH    (SIDE_W)
    ) u_pass2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_p1_valid),
        .i_vec   (w_p1_cart),
        .i_x     (n_p2_x),
        .i_y     (n_p2_y),
        .i_ang   (n_p2_ang),
        .i_side  (n_p2_side),
        .o_valid (w_p2_valid),
        .o_x     (w_p2_x),
        .o_y     (w_p2_y),
        .o_ang   (w_p2_ang),
        .o_mag   (w_p2_mag),
        .o_side  (w_p2_side_raw)
    );

    assign w_p2_side = t_side'(w_p2_side_raw);

    // ---------------- result assembly ----------------
    function automatic logic [CW:0] to_coord(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] r;
        r = (v + HALF_LSB) >>> GUARD;
        if (r > C_MAX) begin
            return {1'b1, C_MAX[CW-1:0]};
        end
        if (r < C_MIN) begin
            return {1'b1, C_MIN[CW-1:0]};
        end
        return {1'b0, r[CW-1:0]};
    endfunction

    logic signed [ZW-1:0] w_codec_z;
    logic signed [AW:0]   w_codec;
    logic signed [DW-1:0] w_rr;
    logic [CW:0]          w_cx;
    logic [CW:0]          w_cy;
    logic [CW:0]          w_cz;

    always_comb begin
        w_codec_z = w_p2_ang;
        if (w_p2_ang < 0) begin
            w_codec_z = '0;
        end else if (w_p2_ang > PI_Z) begin
            w_codec_z = PI_Z;
        end
    end

    assign w_rr = (w_p2_mag + HALF_LSB) >>> GUARD;
    assign w_cx = to_coord(w_p2_x);
    assign w_cy = to_coord(w_p2_y);
    assign w_cz = to_coord(w_p2_side.zc);

    logic signed [CW-1:0] n_out_x;
    logic signed [CW-1:0] n_out_y;
    logic signed [CW-1:0] n_out_z;
    logic [CW-1:0]        n_out_radius;
    logic signed [AW-1:0] n_out_ra;
    logic signed [AW:0]   n_out_polar;
    logic                 n_out_zv;
    logic                 n_out_sat;

    always_comb begin
        n_out_x      = '0;
        n_out_y      = '0;
        n_out_z      = '0;
        n_out_radius = '0;
        n_out_ra     = '0;
        n_out_polar  = '0;
        n_out_zv     = 1'b0;
        n_out_sat    = 1'b0;
        w_codec      = w_codec_z[AW:0];
        case (w_p2_side.op) inside
            OP_CART_RACODEC, OP_CART_RADEC: begin
                if (w_p2_side.zv) begin
                    n_out_zv = 1'b1;
                end else begin
                    if (w_p2_side.axis) begin
                        n_out_radius = (w_p2_side.zin < 0) ? -w_p2_side.zin : w_p2_side.zin;
                        w_codec      = (w_p2_side.zin < 0) ? PI_P : '0;
                    end else begin
                        n_out_ra     = w_p2_side.ra;
                        n_out_radius = (w_rr > R_MAX) ? R_MAX[CW-1:0] : w_rr[CW-1:0];
                    end
                    n_out_polar = (w_p2_side.op == OP_CART_RACODEC) ? w_codec
                                                                    : HALF_PI_P - w_codec;
                end
            end
            OP_RACODEC_CART, OP_RADEC_CART: begin
                n_out_x   = w_cx[CW-1:0];
                n_out_y   = w_cy[CW-1:0];
                n_out_z   = w_cz[CW-1:0];
                n_out_sat = w_cx[CW] || w_cy[CW] || w_cz[CW];
            end
            OP_RACODEC_RADEC, OP_RADEC_RACODEC: begin
                n_out_radius = w_p2_side.radius;
                n_out_ra     = w_p2_side.ra;
                n_out_polar  = w_p2_side.polar;
            end
            default: begin
            end
        endcase
    end

    logic                 r_out_valid;
    logic signed [CW-1:0] r_out_x;
    logic signed [CW-1:0] r_out_y;
    logic signed [CW-1:0] r_out_z;
    logic [CW-1:0]        r_out_radius;
    logic signed [AW-1:0] r_out_ra;
    logic signed [AW:0]   r_out_polar;
    logic                 r_out_zv;
    logic                 r_out_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_x      <= n_out_x;
            r_out_y      <= n_out_y;
            r_out_z      <= n_out_z;
            r_out_radius <= n_out_radius;
            r_out_ra     <= n_out_ra;
            r_out_polar  <= n_out_polar;
            r_out_zv     <= n_out_zv;
            r_out_sat    <= n_out_sat;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_x       = r_out_x;
    assign o_out_y       = r_out_y;
    assign o_out_z       = r_out_z;
    assign o_out_radius  = r_out_radius;
    assign o_out_ra      = r_out_ra;
    assign o_out_polar   = r_out_polar;
    assign o_zero_vector = r_out_zv;
    assign o_saturated   = r_out_sat;

    // ---------------- checks ----------------
    `CSC_ASSERT_IMP(a_zero_vec_clear, i_clk, i_rst_n, o_valid && o_zero_vector,
        o_out_radius == 0 && o_out_ra == 0 && o_out_polar == 0 && !o_saturated,
        "zero vector result carries nonzero fields")
    `CSC_ASSERT_IMP(a_sat_cartesian, i_clk, i_rst_n, o_valid && o_saturated,
        o_out_radius == 0 && o_out_ra == 0 && o_out_polar == 0,
        "saturation flagged on a spherical result")
    `CSC_ASSERT_IMP(a_forms_disjoint, i_clk, i_rst_n, o_valid && o_out_radius != 0,
        o_out_x == 0 && o_out_y == 0 && o_out_z == 0,
        "both Cartesian and spherical fields set")
    `CSC_ASSERT_NXT(a_pipe_hold, i_clk, i_rst_n, w_p2_valid && !w_en, w_p2_valid,
        "pipeline lost an item while held")

endmodule
